// ===== rtl/periodic_1d_fdtd_field_update_macros.svh =====
// Assertion macros for the periodic 1D FDTD field update block.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef PERIODIC_1D_FDTD_FIELD_UPDATE_MACROS_SVH
`define PERIODIC_1D_FDTD_FIELD_UPDATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFDTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFDTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfdtd_pkg.sv =====
// Shared types, widths and codes for the periodic 1D FDTD field update block.
// No dependencies; imported by the multiply-accumulate unit and the top level.
package pfdtd_pkg;

  localparam int GRID_CELLS_DEF = 1024;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int COEF_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int PROD_W      = DIFF_W + COEF_W;
  localparam int ACC_W       = 43;
  localparam int FRAC_W      = 24;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = 3;
  localparam int IN_TDATA_W  = 272;
  localparam int OUT_TDATA_W = 176;

  localparam logic [STEP_W-1:0] STEP_LAST_B = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_E = 3'd4;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ADV_B = 2'd2,
    CMD_ADV_E = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_SAT   = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_COUNT   = 2'd0,
    REG_COEF_B       = 2'd1,
    REG_COEF_CURRENT = 2'd2,
    REG_COEF_CURL    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_I,
    S_RD_N,
    S_DIFF,
    S_MUL,
    S_DRAIN,
    S_SAT,
    S_DONE
  } fsm_state_t;

  typedef enum logic [1:0] {
    ACC_0,
    ACC_1,
    ACC_2
  } acc_sel_t;

  typedef struct packed {
    logic     vld;
    logic     neg;
    acc_sel_t sel;
  } mac_req_t;

endpackage

// ===== rtl/pfdtd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module pfdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pfdtd_mac.sv =====
// Shared multiplier with three accumulators and 32-bit saturation.
// Depends on pfdtd_pkg.
module pfdtd_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld,
  input  pfdtd_pkg::data_t [2:0]        ld_base,
  input  pfdtd_pkg::mac_req_t           req,
  input  pfdtd_pkg::diff_t              opa,
  input  pfdtd_pkg::coef_t              opk,
  output pfdtd_pkg::data_t [2:0]        sat_val,
  output logic                          sat_flag
);
  import pfdtd_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_shift;
  logic signed [ACC_W-1:0]  term;
  logic                     pvld_r;
  logic                     pneg_r;
  acc_sel_t                 psel_r;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic [2:0]               hit_hi;
  logic [2:0]               hit_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req.vld) begin
      prod_r <= opa * opk;
      pneg_r <= req.neg;
      psel_r <= req.sel;
    end
  end

  // The arithmetic shift of the exact product rounds toward minus infinity.
  assign prod_shift = prod_r >>> FRAC_W;
  assign term       = prod_shift[ACC_W-1:0];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ld) begin
        acc_r[k] <= ACC_W'($signed(ld_base[k]));
      end else if (pvld_r && (psel_r == acc_sel_t'(2'(k)))) begin
        acc_r[k] <= pneg_r ? (acc_r[k] - term) : (acc_r[k] + term);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit_hi[k] = acc_r[k] > SAT_HI;
      hit_lo[k] = acc_r[k] < SAT_LO;
      if (hit_hi[k]) begin
        sat_val[k] = SAT_HI[DATA_W-1:0];
      end else if (hit_lo[k]) begin
        sat_val[k] = SAT_LO[DATA_W-1:0];
      end else begin
        sat_val[k] = acc_r[k][DATA_W-1:0];
      end
    end
    sat_flag = |(hit_hi | hit_lo);
  end

endmodule

// ===== rtl/periodic_1d_fdtd_field_update.sv =====
// Top level of the periodic 1D FDTD field update block: sequencer, grid memories,
// configuration registers and output register. Depends on pfdtd_pkg, pfdtd_ram,
// pfdtd_mac and the assertion macro header.
//
//   Channel | Ports                       | Word
//   in      | in_tvalid/tready/tdata/tuser | one command on one cell
//   out     | out_tvalid/tready/tdata/tuser| cell contents and status
//   cfg     | cfg_we/index/wdata          | one register write, no wait
//
// From accept, a write or bad index passes S_RD_I and S_DONE, a read also S_RD_N,
// and an advance S_RD_N, S_DIFF, S_MUL, S_DRAIN and S_SAT; in_tready returns in the
// same cycle as out word valid. One read port per grid memory serializes the cell and
// neighbor reads, and the single shared multiplier takes one product per cycle.
// Synchronous active-low reset clears control only; the grid memories are not
// cleared. A held out word stalls the sequencer in its last state, and a new
// word is taken while the previous result still waits on the out channel.
`include "periodic_1d_fdtd_field_update_macros.svh"

module periodic_1d_fdtd_field_update #(
  parameter int GRID_CELLS = pfdtd_pkg::GRID_CELLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfdtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfdtd_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cell_index, load_e_x, load_e_y, load_e_z, load_b_y, load_b_z,
  // current_x, current_y, current_z, zero fill
  input  logic [pfdtd_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cmd
  input  logic [pfdtd_pkg::CMD_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_index, out_e_x, out_e_y, out_e_z, out_b_y, out_b_z, zero fill
  output logic [pfdtd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [pfdtd_pkg::STAT_W-1:0]        out_tuser
);
  import pfdtd_pkg::*;

  localparam int AW    = $clog2(GRID_CELLS);
  localparam int NW    = $clog2(GRID_CELLS + 1);
  localparam int CMPW  = (NW > CNT_W) ? NW : CNT_W;
  localparam int E_W   = 3 * DATA_W;
  localparam int B_W   = 2 * DATA_W;
  localparam int PAD_W = OUT_TDATA_W - IDX_W - 5 * DATA_W;
  localparam logic [CMPW-1:0] GRID_N = CMPW'(GRID_CELLS);

  fsm_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [CNT_W-1:0] cnt_r;
  coef_t            kb_r, kc_r, kl_r;

  cmd_t             cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic             ok_r;
  data_t            ld_ex_r, ld_ey_r, ld_ez_r, ld_by_r, ld_bz_r;
  data_t            cx_r, cy_r, cz_r;
  data_t            cur_ex_r, cur_ey_r, cur_ez_r, cur_by_r, cur_bz_r;
  diff_t            d0_r, d1_r;

  data_t            res_ex_nxt, res_ey_nxt, res_ez_nxt, res_by_nxt, res_bz_nxt;
  status_t          res_st_nxt;
  logic             res_ld;
  data_t            res_ex_r, res_ey_r, res_ez_r, res_by_r, res_bz_r;
  status_t          res_st_r;
  logic [IDX_W-1:0] res_idx_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  status_t                out_st_r;
  logic                   out_ld;

  logic            in_acc;
  logic [CMPW-1:0] n_eff, in_idx_ext, idx_ext, nb_j, nb_p, idx_inc;
  logic [AW-1:0]   addr_i, addr_j, addr_p, rd_addr;

  logic             e_we, b_we;
  logic [E_W-1:0]   e_wdata, e_rdata;
  logic [B_W-1:0]   b_wdata, b_rdata;
  data_t            rd_ex, rd_ey, rd_ez, rd_by, rd_bz;

  logic             mac_ld;
  data_t [2:0]      mac_base;
  mac_req_t         mac_req;
  diff_t            mac_a;
  coef_t            mac_k;
  data_t [2:0]      mac_sat;
  logic             mac_flag;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  // Active count and periodic neighbors.
  always_comb begin
    n_eff      = (CMPW'(cnt_r) > GRID_N) ? GRID_N : CMPW'(cnt_r);
    in_idx_ext = CMPW'(in_tdata[IDX_W-1:0]);
    idx_ext    = CMPW'(idx_r);
    idx_inc    = idx_ext + CMPW'(1);
    nb_j       = (idx_inc >= n_eff) ? '0 : idx_inc;
    nb_p       = (idx_ext == '0) ? (n_eff - CMPW'(1)) : (idx_ext - CMPW'(1));
    addr_i     = idx_ext[AW-1:0];
    addr_j     = nb_j[AW-1:0];
    addr_p     = nb_p[AW-1:0];
  end

  assign rd_ex = $signed(e_rdata[DATA_W-1:0]);
  assign rd_ey = $signed(e_rdata[2*DATA_W-1:DATA_W]);
  assign rd_ez = $signed(e_rdata[3*DATA_W-1:2*DATA_W]);
  assign rd_by = $signed(b_rdata[DATA_W-1:0]);
  assign rd_bz = $signed(b_rdata[2*DATA_W-1:DATA_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(GRID_CELLS_DEF);
      kb_r  <= '0;
      kc_r  <= '0;
      kl_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_COUNT:   cnt_r <= cfg_wdata[CNT_W-1:0];
        REG_COEF_B:       kb_r  <= cfg_wdata;
        REG_COEF_CURRENT: kc_r  <= cfg_wdata;
        REG_COEF_CURL:    kl_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= cmd_t'(in_tuser);
      idx_r   <= in_tdata[IDX_W-1:0];
      ok_r    <= in_idx_ext < n_eff;
      ld_ex_r <= $signed(in_tdata[IDX_W+1*DATA_W-1:IDX_W+0*DATA_W]);
      ld_ey_r <= $signed(in_tdata[IDX_W+2*DATA_W-1:IDX_W+1*DATA_W]);
      ld_ez_r <= $signed(in_tdata[IDX_W+3*DATA_W-1:IDX_W+2*DATA_W]);
      ld_by_r <= $signed(in_tdata[IDX_W+4*DATA_W-1:IDX_W+3*DATA_W]);
      ld_bz_r <= $signed(in_tdata[IDX_W+5*DATA_W-1:IDX_W+4*DATA_W]);
      cx_r    <= $signed(in_tdata[IDX_W+6*DATA_W-1:IDX_W+5*DATA_W]);
      cy_r    <= $signed(in_tdata[IDX_W+7*DATA_W-1:IDX_W+6*DATA_W]);
      cz_r    <= $signed(in_tdata[IDX_W+8*DATA_W-1:IDX_W+7*DATA_W]);
    end
    if (state_r == S_RD_N) begin
      cur_ex_r <= rd_ex;
      cur_ey_r <= rd_ey;
      cur_ez_r <= rd_ez;
      cur_by_r <= rd_by;
      cur_bz_r <= rd_bz;
    end
    if (state_r == S_DIFF) begin
      if (cmd_r == CMD_ADV_B) begin
        d0_r <= DIFF_W'(rd_ez) - DIFF_W'(cur_ez_r);
        d1_r <= DIFF_W'(rd_ey) - DIFF_W'(cur_ey_r);
      end else begin
        d0_r <= DIFF_W'(cur_bz_r) - DIFF_W'(rd_bz);
        d1_r <= DIFF_W'(cur_by_r) - DIFF_W'(rd_by);
      end
    end
    if (res_ld) begin
      res_ex_r  <= res_ex_nxt;
      res_ey_r  <= res_ey_nxt;
      res_ez_r  <= res_ez_nxt;
      res_by_r  <= res_by_nxt;
      res_bz_r  <= res_bz_nxt;
      res_st_r  <= res_st_nxt;
      res_idx_r <= idx_r;
    end
    if (out_ld) begin
      out_data_r <= {{PAD_W{1'b0}}, res_bz_r, res_by_r, res_ez_r, res_ey_r, res_ex_r,
                     res_idx_r};
      out_st_r   <= res_st_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    rd_addr    = addr_i;
    e_we       = 1'b0;
    b_we       = 1'b0;
    e_wdata    = {ld_ez_r, ld_ey_r, ld_ex_r};
    b_wdata    = {ld_bz_r, ld_by_r};
    mac_ld     = 1'b0;
    mac_base   = '0;
    mac_req    = '0;
    mac_a      = '0;
    mac_k      = '0;
    res_ld     = 1'b0;
    res_ex_nxt = '0;
    res_ey_nxt = '0;
    res_ez_nxt = '0;
    res_by_nxt = '0;
    res_bz_nxt = '0;
    res_st_nxt = STAT_OK;
    out_ld     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD_I;
        end
      end
      S_RD_I: begin
        priority if (!ok_r) begin
          res_ld     = 1'b1;
          res_st_nxt = STAT_RANGE;
          state_nxt  = S_DONE;
        end else if (cmd_r == CMD_WRITE) begin
          e_we       = 1'b1;
          b_we       = 1'b1;
          res_ld     = 1'b1;
          res_ex_nxt = ld_ex_r;
          res_ey_nxt = ld_ey_r;
          res_ez_nxt = ld_ez_r;
          res_by_nxt = ld_by_r;
          res_bz_nxt = ld_bz_r;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_RD_N;
        end
      end
      S_RD_N: begin
        priority if (cmd_r == CMD_ADV_B) begin
          rd_addr   = addr_j;
          mac_ld    = 1'b1;
          mac_base  = {data_t'('0), rd_bz, rd_by};
          state_nxt = S_DIFF;
        end else if (cmd_r == CMD_ADV_E) begin
          rd_addr   = addr_p;
          mac_ld    = 1'b1;
          mac_base  = {rd_ez, rd_ey, rd_ex};
          state_nxt = S_DIFF;
        end else begin
          res_ld     = 1'b1;
          res_ex_nxt = rd_ex;
          res_ey_nxt = rd_ey;
          res_ez_nxt = rd_ez;
          res_by_nxt = rd_by;
          res_bz_nxt = rd_bz;
          state_nxt  = S_DONE;
        end
      end
      S_DIFF: begin
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mac_req.vld = 1'b1;
        mac_req.neg = 1'b1;
        if (cmd_r == CMD_ADV_B) begin
          mac_k = kb_r;
          if (step_r == '0) begin
            mac_a       = d0_r;
            mac_req.sel = ACC_0;
            mac_req.neg = 1'b0;
          end else begin
            mac_a       = d1_r;
            mac_req.sel = ACC_1;
          end
        end else begin
          priority case (step_r)
            3'd0: begin
              mac_a = DIFF_W'(cx_r);
              mac_k = kc_r;
              mac_req.sel = ACC_0;
            end
            3'd1: begin
              mac_a = DIFF_W'(cy_r);
              mac_k = kc_r;
              mac_req.sel = ACC_1;
            end
            3'd2: begin
              mac_a = d0_r;
              mac_k = kl_r;
              mac_req.sel = ACC_1;
            end
            3'd3: begin
              mac_a = DIFF_W'(cz_r);
              mac_k = kc_r;
              mac_req.sel = ACC_2;
            end
            default: begin
              mac_a = d1_r;
              mac_k = kl_r;
              mac_req.sel = ACC_2;
              mac_req.neg = 1'b0;
            end
          endcase
        end
        if (step_r == ((cmd_r == CMD_ADV_B) ? STEP_LAST_B : STEP_LAST_E)) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_SAT;
      end
      S_SAT: begin
        res_ld     = 1'b1;
        res_st_nxt = mac_flag ? STAT_SAT : STAT_OK;
        if (cmd_r == CMD_ADV_B) begin
          b_we       = 1'b1;
          b_wdata    = {mac_sat[1], mac_sat[0]};
          res_ex_nxt = cur_ex_r;
          res_ey_nxt = cur_ey_r;
          res_ez_nxt = cur_ez_r;
          res_by_nxt = mac_sat[0];
          res_bz_nxt = mac_sat[1];
        end else begin
          e_we       = 1'b1;
          e_wdata    = {mac_sat[2], mac_sat[1], mac_sat[0]};
          res_ex_nxt = mac_sat[0];
          res_ey_nxt = mac_sat[1];
          res_ez_nxt = mac_sat[2];
          res_by_nxt = cur_by_r;
          res_bz_nxt = cur_bz_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  pfdtd_ram #(
    .WIDTH (E_W),
    .DEPTH (GRID_CELLS)
  ) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (addr_i),
    .wdata (e_wdata),
    .raddr (rd_addr),
    .rdata (e_rdata)
  );

  pfdtd_ram #(
    .WIDTH (B_W),
    .DEPTH (GRID_CELLS)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (addr_i),
    .wdata (b_wdata),
    .raddr (rd_addr),
    .rdata (b_rdata)
  );

  pfdtd_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (mac_ld),
    .ld_base  (mac_base),
    .req      (mac_req),
    .opa      (mac_a),
    .opk      (mac_k),
    .sat_val  (mac_sat),
    .sat_flag (mac_flag)
  );

  `PFDTD_ASSERT_IMP(a_no_write_bad_idx, e_we || b_we, ok_r, "grid written by bad index")
  `PFDTD_ASSERT_IMP(a_out_slot_free, out_ld, !out_valid_r || out_tready, "out word overwritten")
  `PFDTD_ASSERT_IMP(a_mul_step_bound, state_r == S_MUL, step_r <= STEP_LAST_E, "product overrun")
  `PFDTD_ASSERT_NXT(a_accept_starts, in_acc, state_r == S_RD_I && !in_tready, "word not started")

endmodule
